@@ rtl/calendar_date_stepper_macros.svh @@
// Assertion helpers for the date stepper.
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cds_pkg.sv @@
`default_nettype none

package cds_pkg;

  localparam int STEP_BITS = 16;
  localparam int CNT_W     = STEP_BITS + 1;

  localparam logic [11:0] YEAR_LO  = 12'd1970;
  localparam logic [11:0] YEAR_HI  = 12'd2037;
  localparam logic [11:0] YEAR_MAX = 12'd4095;
  localparam logic [11:0] YEAR_RST = 12'd1970;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic               mode;
    logic [4:0]         new_day;
    logic [3:0]         new_month;
    logic [11:0]        new_year;
    logic signed [15:0] step_count;
  } cds_in_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [11:0] cur_year;
    logic        load_rejected;
    logic        range_hit;
  } cds_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_LD,
    ST_LOAD,
    ST_LEAP_WK,
    ST_WALK,
    ST_DONE
  } cds_state_t;

  typedef enum logic {
    LEAP_CUR,
    LEAP_LD
  } leap_sel_t;

  typedef struct packed {
    logic      capture;
    leap_sel_t leap_sel;
    logic      load_exec;
    logic      walk_exec;
    logic      out_load;
  } cds_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } cds_stat_t;

  // y/100 by reciprocal multiply (exact for 12-bit years), then the usual rule
  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic [5:0]  q;
    logic [11:0] hund;
    prod = {13'd0, y} * 25'd5243;
    q    = prod[24:19];
    hund = {q, 6'd0} + {1'b0, q, 5'd0} + {4'd0, q, 2'd0};
    return (y == 12'd0) || ((y[1:0] == 2'd0) && ((y != hund) || (q[1:0] == 2'd0)));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/calendar_date_stepper.sv @@
// Calendar date stepper: holds a Gregorian date and loads or steps it.
// Input channel (in_valid / in_stall / in_data): one beat is either a load
// (mode 0: date checked for 1970..2037 and a real day of month) or a step
// (mode 1: signed day count). Result channel (out_valid / out_stall /
// out_data): one beat per input beat with the date afterwards, a reject flag
// for a bad load and a flag when a step ran into 1 Jan 0 or 31 Dec 4095.
// Order of work: a load goes through a leap lookup for the new year, then the
// check and load, then the output register. A step walks one month per pass
// (leap lookup, then month update) until the count is used up or a bound is
// hit, then loads the output register.
// One item is in work at a time; in_stall is low only while idle. The result
// sits in an output register, so the next beat is taken while it waits.
// While out_stall is high the result beat holds and a finished item waits
// in the controller until the register frees.
// Reset (synchronous, rst_n low) sets the date to 1 Jan 1970 and clears both
// channels.
`default_nettype none
`include "calendar_date_stepper_macros.svh"

module calendar_date_stepper import cds_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire cds_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output cds_out_t     out_data
);

  cds_cmd_t  cmd;
  cds_stat_t stat;

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cds_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `CDS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not busy the block")
  `CDS_ASSERT_IMP(a_flags_exclusive, out_valid, !(out_data.load_rejected && out_data.range_hit), "both flags set")
  `CDS_ASSERT_IMP(a_hit_at_bound, out_valid && out_data.range_hit, ((out_data.cur_day == 5'd31) && (out_data.cur_month == MON_DEC) && (out_data.cur_year == YEAR_MAX)) || ((out_data.cur_day == 5'd1) && (out_data.cur_month == MON_JAN) && (out_data.cur_year == 12'd0)), "range hit away from a bound")

endmodule

`default_nettype wire

@@ rtl/cds_ctrl.sv @@
`default_nettype none

module cds_ctrl import cds_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_mode,
  output logic           in_stall,
  input  wire cds_stat_t stat,
  output cds_cmd_t       cmd
);

  cds_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.leap_sel  = LEAP_CUR;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_mode ? ST_LEAP_WK : ST_LEAP_LD;
        end
      end
      ST_LEAP_LD: begin
        cmd.leap_sel = LEAP_LD;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_exec = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_LEAP_WK: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_exec = 1'b1;
        state_nxt     = stat.walk_done ? ST_DONE : ST_LEAP_WK;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cds_datapath.sv @@
`default_nettype none

module cds_datapath import cds_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cds_in_t  in_data,
  input  wire cds_cmd_t cmd,
  output cds_stat_t     stat,
  output logic          out_valid,
  output cds_out_t      out_data,
  input  wire logic     out_stall
);

  logic [4:0]       day_r, day_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [11:0]      year_r, year_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             back_r, back_nxt;
  logic             fill_r, fill_nxt;
  logic             rej_r, rej_nxt;
  logic             hit_r, hit_nxt;
  logic [4:0]       ld_day_r;
  logic [3:0]       ld_month_r;
  logic [11:0]      ld_year_r;
  logic             leap_r;
  logic             out_valid_r, out_valid_nxt;
  cds_out_t         out_data_r;

  logic [11:0]      leap_src;
  logic [4:0]       len;
  logic [4:0]       day_eff;
  logic [4:0]       left;
  logic             fwd_fits, bwd_fits, at_top, at_bot;
  logic             ld_ok;
  logic [CNT_W-1:0] step_ext;
  logic [CNT_W-1:0] step_mag;

  assign leap_src = (cmd.leap_sel == LEAP_LD) ? ld_year_r : year_r;
  assign len      = month_len(month_r, leap_r);
  // after a backward month change the day is the new month's last day
  assign day_eff  = fill_r ? len : day_r;
  assign left     = len - day_r;
  assign fwd_fits = cnt_r <= CNT_W'(left);
  assign bwd_fits = cnt_r < CNT_W'(day_eff);
  assign at_top   = (month_r == MON_DEC) && (year_r == YEAR_MAX);
  assign at_bot   = (month_r == MON_JAN) && (year_r == 12'd0);

  assign stat.walk_done = back_r ? (bwd_fits || at_bot) : (fwd_fits || at_top);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign ld_ok = (ld_year_r >= YEAR_LO) && (ld_year_r <= YEAR_HI) &&
                 (ld_month_r >= MON_JAN) && (ld_month_r <= MON_DEC) &&
                 (ld_day_r != 5'd0) && (ld_day_r <= month_len(ld_month_r, leap_r));

  assign step_ext = CNT_W'(signed'(in_data.step_count[STEP_BITS-1:0]));
  assign step_mag = in_data.step_count[STEP_BITS-1] ? (CNT_W'(0) - step_ext) : step_ext;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    cnt_nxt   = cnt_r;
    back_nxt  = back_r;
    fill_nxt  = fill_r;
    rej_nxt   = rej_r;
    hit_nxt   = hit_r;
    if (cmd.capture) begin
      cnt_nxt  = step_mag;
      back_nxt = in_data.step_count[STEP_BITS-1];
      fill_nxt = 1'b0;
      rej_nxt  = 1'b0;
      hit_nxt  = 1'b0;
    end else if (cmd.load_exec) begin
      if (ld_ok) begin
        day_nxt   = ld_day_r;
        month_nxt = ld_month_r;
        year_nxt  = ld_year_r;
      end else begin
        rej_nxt = 1'b1;
      end
    end else if (cmd.walk_exec) begin
      if (back_r) begin
        fill_nxt = 1'b0;
        if (bwd_fits) begin
          day_nxt = day_eff - cnt_r[4:0];
        end else if (at_bot) begin
          day_nxt = 5'd1;
          hit_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r - CNT_W'(day_eff);
          fill_nxt = 1'b1;
          if (month_r == MON_JAN) begin
            month_nxt = MON_DEC;
            year_nxt  = year_r - 12'd1;
          end else begin
            month_nxt = month_r - 4'd1;
          end
        end
      end else begin
        if (fwd_fits) begin
          day_nxt = day_r + cnt_r[4:0];
        end else if (at_top) begin
          day_nxt = 5'd31;
          hit_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - (CNT_W'(left) + CNT_W'(1));
          day_nxt = 5'd1;
          if (month_r == MON_DEC) begin
            month_nxt = MON_JAN;
            year_nxt  = year_r + 12'd1;
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r       <= 5'd1;
      month_r     <= MON_JAN;
      year_r      <= YEAR_RST;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    back_r <= back_nxt;
    rej_r  <= rej_nxt;
    hit_r  <= hit_nxt;
    leap_r <= is_leap(leap_src);
    if (cmd.capture) begin
      ld_day_r   <= in_data.new_day;
      ld_month_r <= in_data.new_month;
      ld_year_r  <= in_data.new_year;
    end
    if (cmd.out_load) begin
      out_data_r.cur_day       <= day_r;
      out_data_r.cur_month     <= month_r;
      out_data_r.cur_year      <= year_r;
      out_data_r.load_rejected <= rej_r;
      out_data_r.range_hit     <= hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
